[hdl/spdf_pkg.sv]
// Shared types, constants and the CRC-32 byte update for the serial frame parser.
package spdf_pkg;

  // What each result item carries in its result_kind field.
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_NACK    = 2'd2,
    KIND_ABORT   = 2'd3
  } result_kind_e;

  // Input item kinds, carried on cmd.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Configuration register indices.
  localparam logic [1:0] CFG_START_MARKER = 2'd0;
  localparam logic [1:0] CFG_MAX_LEN      = 2'd1;
  localparam logic [1:0] CFG_IDLE_TIMEOUT = 2'd2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [7:0]  StartMarkerRst = 8'hAA;
  localparam logic [15:0] MaxLenRst      = 16'd256;
  localparam logic [15:0] IdleTimeoutRst = 16'd100;

  localparam logic [2:0]  TrailerBytes = 3'd4;
  localparam int unsigned BitsPerByte  = 8;
  localparam logic [31:0] CrcPoly      = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit      = 32'hFFFF_FFFF;

  // One byte of reflected CRC-32, LSB first.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int unsigned i = 0; i < BitsPerByte; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[hdl/serial_packet_deframer_crc32_top.sv]
// Length-prefixed serial frame parser with CRC-32 check: top level.
//
// Input channel (in_valid_i / in_ready_o): one item per handshake, either a
// received byte (cmd_i = 0, rx_data_i) or a one millisecond tick (cmd_i = 1).
// Output channel (out_valid_o / out_ready_i): payload bytes as they arrive,
// then an ack or nack verdict carrying command and length once the four
// big-endian CRC bytes are in, or an abort when silence mid-frame outlasts
// the idle timeout. Oversize frames are dropped with no result at all.
// Config port: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 start marker, 1 max payload length, 2 idle timeout); other indices
// are ignored. Write only while the block is idle.
// Result: an item's result (if any) goes into the result register at the edge
// that accepts the item. Throughput: one item per cycle unless stalled as below;
// the parser state, the byte-wide CRC update and the verdict compare all sit
// between the accept edge and the result register.
// Stall: the result register holds while out_ready_i is low; a new item is
// still taken when the result register is empty or being drained that cycle.
// Reset: parser hunts for the start marker, registers take their defaults,
// output is empty. There is no clearing pass.
module serial_packet_deframer_crc32_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [spdf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [spdf_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            cmd_i,
  input  logic [7:0]                      rx_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      result_kind_o,
  output logic [7:0]                      payload_byte_o,
  output logic [7:0]                      frame_command_o,
  output logic [15:0]                     frame_length_o
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_CMD     = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_TRAILER = 3'd5
  } phase_e;

  localparam logic [16:0] IdleMax = '1;

  // config registers
  logic [7:0]  start_marker_q;
  logic [15:0] max_len_q;
  logic [15:0] idle_timeout_q;

  // parser state
  phase_e      phase_q, phase_d;
  logic [7:0]  held_cmd_q, held_cmd_d;
  logic [15:0] held_len_q, held_len_d;
  logic [15:0] payload_cnt_q, payload_cnt_d;
  logic [2:0]  trailer_cnt_q, trailer_cnt_d;
  logic [31:0] rx_chk_q, rx_chk_d;
  logic [31:0] crc_q, crc_d;
  logic [16:0] idle_q, idle_d;

  // result register
  logic                   out_valid_q;
  spdf_pkg::result_kind_e kind_q, kind_d;
  logic [7:0]             pbyte_q, pbyte_d;
  logic [7:0]             fcmd_q, fcmd_d;
  logic [15:0]            flen_q, flen_d;
  logic                   emit_d;

  logic        in_fire;
  logic [15:0] len_full;
  logic [15:0] payload_cnt_inc;
  logic [16:0] idle_inc;
  logic [2:0]  trailer_cnt_inc;
  logic [31:0] rx_chk_shift;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign len_full        = {held_len_q[15:8], rx_data_i};
  assign payload_cnt_inc = payload_cnt_q + 16'd1;
  assign idle_inc        = (idle_q == IdleMax) ? idle_q : idle_q + 17'd1;
  assign trailer_cnt_inc = trailer_cnt_q + 3'd1;
  assign rx_chk_shift    = {rx_chk_q[23:0], rx_data_i};

  always_comb begin
    phase_d       = phase_q;
    held_cmd_d    = held_cmd_q;
    held_len_d    = held_len_q;
    payload_cnt_d = payload_cnt_q;
    trailer_cnt_d = trailer_cnt_q;
    rx_chk_d      = rx_chk_q;
    crc_d         = crc_q;
    idle_d        = idle_q;
    emit_d        = 1'b0;
    kind_d        = spdf_pkg::KIND_PAYLOAD;
    pbyte_d       = 8'd0;
    fcmd_d        = 8'd0;
    flen_d        = 16'd0;

    if (cmd_i == spdf_pkg::CMD_TICK) begin
      if (phase_q != PH_HUNT) begin
        idle_d = idle_inc;
        if (idle_inc > {1'b0, idle_timeout_q}) begin
          // silence too long mid-frame: abort with what we have so far
          phase_d = PH_HUNT;
          idle_d  = '0;
          emit_d  = 1'b1;
          kind_d  = spdf_pkg::KIND_ABORT;
          fcmd_d  = held_cmd_q;
          flen_d  = held_len_q;
        end
      end
    end else begin
      idle_d = '0;
      unique case (phase_q)
        PH_CMD: begin
          held_cmd_d = rx_data_i;
          phase_d    = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          held_len_d = {rx_data_i, 8'd0};
          phase_d    = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          held_len_d = len_full;
          if (len_full > max_len_q) begin
            phase_d = PH_HUNT; // oversize, dropped silently
          end else begin
            payload_cnt_d = '0;
            trailer_cnt_d = '0;
            rx_chk_d      = '0;
            crc_d         = spdf_pkg::CrcInit;
            phase_d       = (len_full != 16'd0) ? PH_PAYLOAD : PH_TRAILER;
          end
        end
        PH_PAYLOAD: begin
          crc_d         = spdf_pkg::crc32_byte(crc_q, rx_data_i);
          payload_cnt_d = payload_cnt_inc;
          if (payload_cnt_inc >= held_len_q) begin
            phase_d       = PH_TRAILER;
            trailer_cnt_d = '0;
          end
          emit_d  = 1'b1;
          kind_d  = spdf_pkg::KIND_PAYLOAD;
          pbyte_d = rx_data_i;
        end
        PH_TRAILER: begin
          rx_chk_d      = rx_chk_shift;
          trailer_cnt_d = trailer_cnt_inc;
          if (trailer_cnt_inc >= spdf_pkg::TrailerBytes) begin
            phase_d       = PH_HUNT;
            trailer_cnt_d = '0;
            emit_d        = 1'b1;
            kind_d        = ((~crc_q) == rx_chk_shift) ? spdf_pkg::KIND_ACK
                                                       : spdf_pkg::KIND_NACK;
            fcmd_d        = held_cmd_q;
            flen_d        = held_len_q;
          end
        end
        default: begin
          // hunting; marker mid-frame is plain data, handled above
          if (rx_data_i == start_marker_q) begin
            held_cmd_d = '0;
            held_len_d = '0;
            phase_d    = PH_CMD;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= spdf_pkg::StartMarkerRst;
      max_len_q      <= spdf_pkg::MaxLenRst;
      idle_timeout_q <= spdf_pkg::IdleTimeoutRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        spdf_pkg::CFG_START_MARKER: start_marker_q <= cfg_data_i[7:0];
        spdf_pkg::CFG_MAX_LEN:      max_len_q      <= cfg_data_i;
        spdf_pkg::CFG_IDLE_TIMEOUT: idle_timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_HUNT;
      held_cmd_q    <= '0;
      held_len_q    <= '0;
      payload_cnt_q <= '0;
      trailer_cnt_q <= '0;
      rx_chk_q      <= '0;
      crc_q         <= spdf_pkg::CrcInit;
      idle_q        <= '0;
    end else if (in_fire) begin
      phase_q       <= phase_d;
      held_cmd_q    <= held_cmd_d;
      held_len_q    <= held_len_d;
      payload_cnt_q <= payload_cnt_d;
      trailer_cnt_q <= trailer_cnt_d;
      rx_chk_q      <= rx_chk_d;
      crc_q         <= crc_d;
      idle_q        <= idle_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_fire && emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit_d) begin
      kind_q  <= kind_d;
      pbyte_q <= pbyte_d;
      fcmd_q  <= fcmd_d;
      flen_q  <= flen_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = kind_q;
  assign payload_byte_o  = pbyte_q;
  assign frame_command_o = fcmd_q;
  assign frame_length_o  = flen_q;

`ifndef NO_ASSERTIONS
  a_trailer_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trailer_cnt_q < spdf_pkg::TrailerBytes)
    else $error("trailer count past CRC length");

  a_payload_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> payload_cnt_q < held_len_q)
    else $error("payload count reached length while still in payload");

  a_hunt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HUNT |-> idle_q == 17'd0)
    else $error("idle counter running while hunting");

  a_payload_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == spdf_pkg::KIND_PAYLOAD
      |-> frame_command_o == 8'd0 && frame_length_o == 16'd0)
    else $error("payload item carries frame fields");
`endif

endmodule

[verif/tb.sv]
// Self-checking regression for the serial frame parser with CRC-32 check.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned ResetCycles  = 7;
  localparam int unsigned StallLimit   = 4000;  // longest correct stall is the receiver hold-off
  localparam int unsigned SettleCycles = 4;     // result is registered when its item is accepted
  localparam int unsigned MaxReports   = 40;
  localparam int unsigned HoldOffLen   = 300;
  localparam int unsigned FullFrame    = 32'hFFFF_FFFF;
  localparam logic [spdf_pkg::CfgIdxW-1:0] CFG_SPARE_IDX = 2'd3;  // no register behind it
  localparam logic [16:0] QuietMax = 17'h1_FFFF;

  typedef enum logic [2:0] {
    PH_HUNT, PH_CMD, PH_LEN_HI, PH_LEN_LO, PH_PAYLOAD, PH_TRAILER
  } parse_phase_e;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_RARE} ready_mode_e;

  typedef struct packed {
    spdf_pkg::result_kind_e kind;
    logic [7:0]             data;
    logic [7:0]             command;
    logic [15:0]            length;
  } deframe_result_t;

  // DUT pins, inputs all known from time zero
  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [spdf_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [spdf_pkg::CfgDataW-1:0] cfg_data_i  = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic                          cmd_i       = spdf_pkg::CMD_BYTE;
  logic [7:0]                    rx_data_i   = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [1:0]                    result_kind_o;
  logic [7:0]                    payload_byte_o;
  logic [7:0]                    frame_command_o;
  logic [15:0]                   frame_length_o;

  // Predicted register contents
  logic [7:0]  exp_marker  = spdf_pkg::StartMarkerRst;
  logic [15:0] exp_max_len = spdf_pkg::MaxLenRst;
  logic [15:0] exp_timeout = spdf_pkg::IdleTimeoutRst;

  // Predicted parser state
  parse_phase_e ph           = PH_HUNT;
  logic [7:0]   cur_cmd      = '0;
  logic [15:0]  cur_len      = '0;
  logic [15:0]  payload_seen = '0;
  logic [2:0]   trailer_seen = '0;
  logic [31:0]  crc_rx       = '0;
  logic [31:0]  crc_run      = spdf_pkg::CrcInit;
  logic [16:0]  quiet_ticks  = '0;

  // Results still owed by the DUT, oldest first
  deframe_result_t rx_results_due[$];
  deframe_result_t due;

  int unsigned error_count     = 0;
  int unsigned results_checked = 0;
  int unsigned items_sent      = 0;
  int unsigned kind_count[4]   = '{0, 0, 0, 0};
  int unsigned stall_cycles    = 0;
  int unsigned burst_left      = 0;
  int unsigned hold_off_request = 0;
  int unsigned hold_left       = 0;
  int unsigned ready_cycle     = 0;
  ready_mode_e ready_mode      = RDY_ALWAYS;
  bit          sender_bursty   = 1'b0;

  serial_packet_deframer_crc32_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .rx_data_i      (rx_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .payload_byte_o (payload_byte_o),
    .frame_command_o(frame_command_o),
    .frame_length_o (frame_length_o)
  );

  always #4 clk_i = ~clk_i;

  // Reflected CRC-32, one byte, LSB first: shift right and fold the poly in
  // whenever the bit falling out is set.
  function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    repeat (spdf_pkg::BitsPerByte) c = (c >> 1) ^ (spdf_pkg::CrcPoly & {32{c[0]}});
    return c;
  endfunction

  // Advance the parser prediction by one accepted item and queue any result.
  task automatic predict_item(input logic is_tick, input logic [7:0] b);
    deframe_result_t r;
    r.kind    = spdf_pkg::KIND_PAYLOAD;
    r.data    = 8'h00;
    r.command = 8'h00;
    r.length  = 16'h0000;
    if (is_tick == spdf_pkg::CMD_TICK) begin
      // ticks only matter mid-frame; silence beyond the timeout aborts
      if (ph != PH_HUNT) begin
        if (quiet_ticks != QuietMax) quiet_ticks = quiet_ticks + 17'd1;
        if (quiet_ticks > {1'b0, exp_timeout}) begin
          ph          = PH_HUNT;
          quiet_ticks = '0;
          r.kind      = spdf_pkg::KIND_ABORT;
          r.command   = cur_cmd;
          r.length    = cur_len;  // may be only half received
          rx_results_due.push_back(r);
        end
      end
    end else begin
      quiet_ticks = '0;
      case (ph)
        PH_HUNT: begin
          if (b == exp_marker) begin
            cur_cmd = '0;
            cur_len = '0;
            ph      = PH_CMD;
          end
        end
        PH_CMD: begin
          cur_cmd = b;
          ph      = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          cur_len = {b, 8'h00};
          ph      = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          cur_len[7:0] = b;
          if (cur_len > exp_max_len) begin
            ph = PH_HUNT;  // oversize: dropped without a word
          end else begin
            payload_seen = '0;
            trailer_seen = '0;
            crc_rx       = '0;
            crc_run      = spdf_pkg::CrcInit;
            ph           = (cur_len != 16'd0) ? PH_PAYLOAD : PH_TRAILER;
          end
        end
        PH_PAYLOAD: begin
          crc_run      = crc32_step(crc_run, b);
          payload_seen = payload_seen + 16'd1;
          if (payload_seen >= cur_len) begin
            ph           = PH_TRAILER;
            trailer_seen = '0;
          end
          r.data = b;
          rx_results_due.push_back(r);
        end
        default: begin
          // big-endian CRC, compared against the inverted running value
          crc_rx       = {crc_rx[23:0], b};
          trailer_seen = trailer_seen + 3'd1;
          if (trailer_seen >= spdf_pkg::TrailerBytes) begin
            r.kind       = (~crc_run == crc_rx) ? spdf_pkg::KIND_ACK : spdf_pkg::KIND_NACK;
            r.command    = cur_cmd;
            r.length     = cur_len;
            ph           = PH_HUNT;
            trailer_seen = '0;
            rx_results_due.push_back(r);
          end
        end
      endcase
    end
  endtask

  // Offer one item and hold it until taken. Valid is dropped here only for a
  // bursty sender's gap, so back-to-back items keep it high across the edge.
  task automatic offer_item(input logic is_tick, input logic [7:0] b);
    int unsigned gap;
    if (sender_bursty) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    in_valid_i <= 1'b1;
    cmd_i      <= is_tick;
    rx_data_i  <= b;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predict_item(is_tick, b);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    offer_item(spdf_pkg::CMD_BYTE, b);
  endtask

  // rx_data is don't-care on a tick; keep it moving anyway
  task automatic send_tick();
    offer_item(spdf_pkg::CMD_TICK, 8'($urandom));
  endtask

  task automatic send_word(input logic [31:0] w);
    send_byte(w[31:24]);
    send_byte(w[23:16]);
    send_byte(w[15:8]);
    send_byte(w[7:0]);
  endtask

  // Sender pause: drop valid, let every owed result drain, then wait out
  // SettleCycles more for items that produce nothing.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (rx_results_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [spdf_pkg::CfgIdxW-1:0] idx,
                           input logic [spdf_pkg::CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      spdf_pkg::CFG_START_MARKER: exp_marker  = val[7:0];
      spdf_pkg::CFG_MAX_LEN:      exp_max_len = val;
      spdf_pkg::CFG_IDLE_TIMEOUT: exp_timeout = val;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [7:0] marker, input logic [15:0] max_len,
                              input logic [15:0] timeout);
    logic [7:0] pad;
    settle();
    pad = 8'($urandom);  // upper bits of the marker write must be ignored
    write_reg(spdf_pkg::CFG_START_MARKER, {pad, marker});
    write_reg(spdf_pkg::CFG_MAX_LEN, max_len);
    write_reg(spdf_pkg::CFG_IDLE_TIMEOUT, timeout);
    write_reg(CFG_SPARE_IDX, 16'($urandom));
  endtask

  // Build a whole frame with random payload and send the first stop_at bytes.
  // Short silences no longer than the timeout are sprinkled between bytes.
  task automatic send_frame(input logic [7:0] command, input logic [15:0] len,
                            input bit bad_crc, input int unsigned stop_at);
    logic [7:0]  fb[$];
    logic [7:0]  b;
    logic [31:0] crc;
    int unsigned i;
    fb.delete();
    fb.push_back(exp_marker);
    fb.push_back(command);
    fb.push_back(len[15:8]);
    fb.push_back(len[7:0]);
    crc = spdf_pkg::CrcInit;
    for (i = 0; i < len && fb.size() < stop_at; i++) begin
      b   = ($urandom_range(0, 7) == 0) ? exp_marker : 8'($urandom);
      crc = crc32_step(crc, b);
      fb.push_back(b);
    end
    crc = ~crc;
    if (bad_crc) crc = crc ^ (32'd1 << $urandom_range(0, 31));
    fb.push_back(crc[31:24]);
    fb.push_back(crc[23:16]);
    fb.push_back(crc[15:8]);
    fb.push_back(crc[7:0]);
    for (i = 0; i < fb.size() && i < stop_at; i++) begin
      if (exp_timeout != 0 && $urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, (exp_timeout < 4) ? exp_timeout : 4)) send_tick();
      send_byte(fb[i]);
    end
  endtask

  // Bring the parser back to hunting: silence where the timeout is short,
  // otherwise filler bytes through to the end of the frame.
  task automatic flush_frame();
    while (ph != PH_HUNT) begin
      if (exp_timeout <= 128) send_tick();
      else send_byte(8'($urandom));
    end
  endtask

  // Reset settings. Noise and a stray tick while hunting, a one-byte frame
  // whose payload is the start marker, an empty frame, an oversize header.
  task automatic test_directed_frames();
    send_byte(8'h55);
    send_tick();
    send_byte(exp_marker);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(exp_marker);
    send_word(~crc32_step(spdf_pkg::CrcInit, exp_marker));
    send_byte(exp_marker);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_word(32'h0000_0000);  // CRC of nothing
    send_byte(exp_marker);
    send_byte(8'h7E);
    send_byte(8'hFF);
    send_byte(8'hFF);
  endtask

  task automatic test_timeouts();
    // zero timeout: the first tick mid-frame aborts
    program_regs(spdf_pkg::StartMarkerRst, spdf_pkg::MaxLenRst, 16'd0);
    send_byte(exp_marker);
    send_byte(8'h5A);
    send_tick();
    send_byte(exp_marker);
    send_byte(8'h33);
    send_byte(8'h01);
    send_tick();  // abort carries the half-built length
    // timeout of three: three ticks survive, the fourth aborts
    program_regs(spdf_pkg::StartMarkerRst, spdf_pkg::MaxLenRst, 16'd3);
    send_byte(exp_marker);
    send_byte(8'h11);
    send_byte(8'h00);
    send_byte(8'h02);
    repeat (3) send_tick();
    send_byte(8'h9C);
    repeat (3) send_tick();
    send_byte(8'h3D);
    repeat (4) send_tick();
  endtask

  // Full-scale length accepted once the limit is at its top, then aborted.
  task automatic test_long_length();
    program_regs(spdf_pkg::StartMarkerRst, 16'hFFFF, 16'd2);
    send_byte(exp_marker);
    send_byte(8'hC3);
    send_byte(8'hFF);
    send_byte(8'hFF);
    repeat (3) send_byte(8'($urandom));
    repeat (3) send_tick();
  endtask

  // Receiver goes quiet for a long stretch while a long frame keeps coming,
  // so the output backs up into the input; then the sender waits it out.
  task automatic test_backpressure();
    program_regs(spdf_pkg::StartMarkerRst, spdf_pkg::MaxLenRst, spdf_pkg::IdleTimeoutRst);
    sender_bursty    = 1'b0;
    hold_off_request = HoldOffLen;
    send_frame(8'($urandom), 16'd60, 1'b0, FullFrame);
    settle();
  endtask

  // Mostly well-formed frames with random content; when noisy, also stray
  // items, oversize headers and frames cut short.
  task automatic test_random_traffic(input logic [7:0] marker, input logic [15:0] max_len,
                                     input logic [15:0] timeout, input int unsigned n_items,
                                     input bit noisy, input bit bursty);
    int unsigned goal;
    int unsigned pick;
    int unsigned cap;
    int unsigned len;
    program_regs(marker, max_len, timeout);
    sender_bursty = bursty;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      cap  = ($urandom_range(0, 9) == 0) ? 64 : 16;
      if (cap > exp_max_len) cap = exp_max_len;
      len = $urandom_range(0, cap);
      if (!noisy || pick < 70) begin
        send_frame(8'($urandom), len[15:0], $urandom_range(0, 3) == 0, FullFrame);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 2) == 0) send_tick();
          else send_byte(($urandom_range(0, 3) == 0) ? exp_marker : 8'($urandom));
        end
      end else if (pick < 92 && exp_max_len != 16'hFFFF) begin
        len = $urandom_range(exp_max_len + 1, 16'hFFFF);
        send_frame(8'($urandom), len[15:0], 1'b0, 4);
      end else begin
        send_frame(8'($urandom), len[15:0], 1'b0, $urandom_range(1, len + 7));
      end
      flush_frame();
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    error_count++;
    if (error_count <= MaxReports)
      $display("mismatch on %s at result %0d: got 0x%0h, want 0x%0h",
               what, results_checked, got, want);
  endtask

  // Result checker: every accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rx_results_due.size() == 0) begin
        flag_mismatch("unexpected result kind", 32'(result_kind_o), 32'd0);
      end else begin
        due = rx_results_due.pop_front();
        if (result_kind_o !== due.kind)
          flag_mismatch("result_kind", 32'(result_kind_o), 32'(due.kind));
        if (payload_byte_o !== due.data)
          flag_mismatch("payload_byte", 32'(payload_byte_o), 32'(due.data));
        if (frame_command_o !== due.command)
          flag_mismatch("frame_command", 32'(frame_command_o), 32'(due.command));
        if (frame_length_o !== due.length)
          flag_mismatch("frame_length", 32'(frame_length_o), 32'(due.length));
        kind_count[due.kind]++;
      end
      results_checked++;
    end
  end

  // Receiver: the stall pattern is redrawn at random periodically; a hold-off
  // request from a test overrides it, holding ready low for the requested length.
  always @(posedge clk_i) begin
    ready_cycle++;
    if (ready_cycle % 64 == 0) ready_mode = ready_mode_e'($urandom_range(0, 3));
    if (hold_off_request != 0) begin
      hold_left        = hold_off_request;
      hold_off_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (ready_mode)
        RDY_ALWAYS: out_ready_i <= 1'b1;
        RDY_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
        RDY_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
        default:    out_ready_i <= (ready_cycle % 8 == 0);
      endcase
    end
  end

  // Watchdog: too long with no handshake on either side means a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("watchdog: %0d cycles without a handshake, %0d results owed",
                 stall_cycles, rx_results_due.size());
        $display("serial_packet_deframer_crc32_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_frames();
    test_timeouts();
    test_long_length();
    test_backpressure();
    test_random_traffic(spdf_pkg::StartMarkerRst, spdf_pkg::MaxLenRst,
                        spdf_pkg::IdleTimeoutRst, 220, 1'b1, 1'b1);
    test_random_traffic(8'h00, 16'h0000, 16'h0000, 100, 1'b1, 1'b1);
    test_random_traffic(8'hFF, 16'hFFFF, 16'hFFFF, 180, 1'b0, 1'b0);
    repeat (3)
      test_random_traffic(8'($urandom), 16'($urandom_range(1, 40)),
                          16'($urandom_range(1, 8)), 170, 1'b1, 1'b1);
    settle();

    $display("covered %0d items in, %0d results out: %0d payload bytes, %0d ack, %0d nack,",
             items_sent, results_checked, kind_count[spdf_pkg::KIND_PAYLOAD],
             kind_count[spdf_pkg::KIND_ACK], kind_count[spdf_pkg::KIND_NACK]);
    $display("%0d abort; markers 00/AA/FF/random, length limits 0 to 65535, timeouts 0 to 65535",
             kind_count[spdf_pkg::KIND_ABORT]);
    if (error_count == 0) begin
      $display("serial_packet_deframer_crc32_top regression: pass");
    end else begin
      $display("serial_packet_deframer_crc32_top regression: fail");
    end
    $finish;
  end

endmodule
